// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bfs_pkg.sv =====
package bfs_pkg;

  // Field widths of the channels
  localparam int CFG_W       = 16;
  localparam int LEVEL_W     = 16;
  localparam int PCT_IN_W    = 16;
  localparam int CMD_W       = 2;
  localparam int PCT_BITS    = 7;
  localparam int COUNT_OUT_W = 32;
  localparam int SUM_OUT_W   = 39;

  // Parameter defaults
  localparam int DEF_LEVEL_BITS = 16;
  localparam int DEF_COUNT_BITS = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LEVEL   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERCENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Percent constants
  localparam logic [PCT_BITS-1:0] PCT_MAX           = 7'd100;
  localparam logic [PCT_BITS-1:0] PCT_QUARTER       = 7'd25;
  localparam logic [PCT_BITS-1:0] PCT_HALF          = 7'd50;
  localparam logic [PCT_BITS-1:0] PCT_THREE_QUARTER = 7'd75;

  // One quotient bit per divider step
  localparam int DIV_STEPS = PCT_BITS;

  typedef struct packed {
    logic capture;
    logic classify;
    logic div_step;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
  } dp_status_t;

endpackage

// ===== rtl/bfs_if.sv =====
interface bfs_item_if import bfs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [LEVEL_W-1:0]         fill_level;
  logic signed [PCT_IN_W-1:0] direct_percent;

  modport source (output valid, cmd, fill_level, direct_percent, input ready);
  modport sink (input valid, cmd, fill_level, direct_percent, output ready);
endinterface

interface bfs_result_if import bfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   reading_taken;
  logic [PCT_BITS-1:0]    this_percent;
  logic [COUNT_OUT_W-1:0] total_readings;
  logic [SUM_OUT_W-1:0]   percent_total;
  logic [PCT_BITS-1:0]    peak_seen;
  logic [COUNT_OUT_W-1:0] over_quarter;
  logic [COUNT_OUT_W-1:0] over_half;
  logic [COUNT_OUT_W-1:0] over_three_quarters;

  modport source (output valid, reading_taken, this_percent, total_readings,
                  percent_total, peak_seen, over_quarter, over_half,
                  over_three_quarters, input ready);
  modport sink (input valid, reading_taken, this_percent, total_readings,
                percent_total, peak_seen, over_quarter, over_half,
                over_three_quarters, output ready);
endinterface

interface bfs_cfg_if import bfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/buffer_fill_statistics.sv =====
// Buffer fill statistics.
// items:   valid/ready channel; each item carries cmd, fill_level and
//          direct_percent. cmd 0 turns fill_level into a rounded percent of
//          the capacity, cmd 1 takes direct_percent clamped to 0..100, cmd 2
//          clears every statistic.
// cfg:     valid/ready write channel for buffer_capacity; always ready.
//          Write only while no item is in flight.
// results: valid/ready channel; one item per input item, carrying the percent
//          recorded and the statistics after that item.
// Flow:    a level reading with a fill below capacity runs a restoring
//          divider for one quotient bit per cycle; every other item goes
//          from classify straight to update. Each item then waits in push
//          for a free output register, and the next item is taken only
//          after that push.
// A finished result sits in the output register; the next item is taken and
// worked on meanwhile, and only its final load waits while the receiver stalls.
// Reset clears the statistics, the capacity and the output valid.
module buffer_fill_statistics import bfs_pkg::*; #(
  parameter int LEVEL_BITS = DEF_LEVEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input logic         clk,
  input logic         rst,
  bfs_cfg_if.sink     cfg,
  bfs_item_if.sink    items,
  bfs_result_if.source results
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       items_ready;
  logic       results_valid;

  assign cfg.ready     = 1'b1;
  assign items.ready   = items_ready;
  assign results.valid = results_valid;

  bfs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .items_valid   (items.valid),
    .items_ready   (items_ready),
    .results_valid (results_valid),
    .results_ready (results.ready),
    .status        (status),
    .cmd           (cmd)
  );

  bfs_dp #(
    .LEVEL_BITS (LEVEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg.valid),
    .cfg_data            (cfg.data),
    .item_cmd            (items.cmd),
    .item_level          (items.fill_level),
    .item_percent        (items.direct_percent),
    .cmd                 (cmd),
    .status              (status),
    .reading_taken       (results.reading_taken),
    .this_percent        (results.this_percent),
    .total_readings      (results.total_readings),
    .percent_total       (results.percent_total),
    .peak_seen           (results.peak_seen),
    .over_quarter        (results.over_quarter),
    .over_half           (results.over_half),
    .over_three_quarters (results.over_three_quarters)
  );

endmodule

// ===== rtl/bfs_ctrl.sv =====
module bfs_ctrl import bfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       items_valid,
  output logic       items_ready,
  output logic       results_valid,
  input  logic       results_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_PUSH     = 3'd4;

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign items_ready = (state == S_IDLE);
  assign out_free    = !results_valid || results_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (items_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_next   = status.needs_div ? S_DIV : S_UPDATE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == LAST_STEP) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      results_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step <= step + 1'b1;
      else step <= '0;
      if (cmd.load_out) results_valid <= 1'b1;
      else if (results_ready) results_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/bfs_dp.sv =====
module bfs_dp import bfs_pkg::*; #(
  parameter int LEVEL_BITS = DEF_LEVEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [CMD_W-1:0]           item_cmd,
  input  logic [LEVEL_W-1:0]         item_level,
  input  logic signed [PCT_IN_W-1:0] item_percent,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 status,
  output logic                       reading_taken,
  output logic [PCT_BITS-1:0]        this_percent,
  output logic [COUNT_OUT_W-1:0]     total_readings,
  output logic [SUM_OUT_W-1:0]       percent_total,
  output logic [PCT_BITS-1:0]        peak_seen,
  output logic [COUNT_OUT_W-1:0]     over_quarter,
  output logic [COUNT_OUT_W-1:0]     over_half,
  output logic [COUNT_OUT_W-1:0]     over_three_quarters
);

  // Only the low bits of level and capacity that both the field and LEVEL_BITS allow
  localparam int LW = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;
  localparam int NW = LW + 9;
  localparam int SW = COUNT_BITS + 7;

  logic [CFG_W-1:0]           capacity;
  logic [CMD_W-1:0]           cmd_r;
  logic [LEVEL_W-1:0]         level_r;
  logic signed [PCT_IN_W-1:0] percent_r;
  logic [PCT_BITS-1:0]        pct;
  logic                       taken;
  logic [NW-1:0]              rem;
  logic [NW-1:0]              divisor;

  logic [COUNT_BITS-1:0] reading_count;
  logic [SW-1:0]         sum_of_percents;
  logic [PCT_BITS-1:0]   peak_percent;
  logic [COUNT_BITS-1:0] quarter_count;
  logic [COUNT_BITS-1:0] half_count;
  logic [COUNT_BITS-1:0] three_quarter_count;

  logic [LW-1:0]       cap;
  logic [LW-1:0]       lvl;
  logic                cap_zero;
  logic                lvl_ge_cap;
  logic [NW-1:0]       numer;
  logic [PCT_BITS-1:0] clamped;
  logic                rem_ge;
  logic [SW:0]         sum_wide;

  assign cap        = capacity[LW-1:0];
  assign lvl        = level_r[LW-1:0];
  assign cap_zero   = (cap == '0);
  assign lvl_ge_cap = (lvl >= cap);

  assign status.needs_div = (cmd_r == CMD_LEVEL) && !cap_zero && !lvl_ge_cap;

  // level * 200 + capacity, as three shifted copies
  assign numer = (NW'(lvl) << 7) + (NW'(lvl) << 6) + (NW'(lvl) << 3) + NW'(cap);

  always_comb begin
    if (percent_r[PCT_IN_W-1]) clamped = '0;
    else if (percent_r > PCT_IN_W'(PCT_MAX)) clamped = PCT_MAX;
    else clamped = percent_r[PCT_BITS-1:0];
  end

  assign rem_ge   = (rem >= divisor);
  assign sum_wide = {1'b0, sum_of_percents} + (SW + 1)'(pct);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= item_cmd;
      level_r   <= item_level;
      percent_r <= item_percent;
    end
    if (cmd.classify) begin
      rem     <= numer;
      divisor <= NW'(cap) << 7;
      case (cmd_r)
        CMD_LEVEL: begin
          taken <= !cap_zero;
          // level at or above a nonzero capacity reads as a full buffer
          pct   <= (!cap_zero && lvl_ge_cap) ? PCT_MAX : '0;
        end
        CMD_PERCENT: begin
          taken <= 1'b1;
          pct   <= clamped;
        end
        default: begin
          taken <= 1'b0;
          pct   <= '0;
        end
      endcase
    end
    if (cmd.div_step) begin
      if (rem_ge) rem <= rem - divisor;
      pct     <= {pct[PCT_BITS-2:0], rem_ge};
      divisor <= divisor >> 1;
    end
    if (cmd.load_out) begin
      reading_taken       <= taken;
      this_percent        <= pct;
      total_readings      <= COUNT_OUT_W'(reading_count);
      percent_total       <= SUM_OUT_W'(sum_of_percents);
      peak_seen           <= peak_percent;
      over_quarter        <= COUNT_OUT_W'(quarter_count);
      over_half           <= COUNT_OUT_W'(half_count);
      over_three_quarters <= COUNT_OUT_W'(three_quarter_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_count       <= '0;
      sum_of_percents     <= '0;
      peak_percent        <= '0;
      quarter_count       <= '0;
      half_count          <= '0;
      three_quarter_count <= '0;
    end else if (cmd.update) begin
      if (cmd_r == CMD_CLEAR) begin
        reading_count       <= '0;
        sum_of_percents     <= '0;
        peak_percent        <= '0;
        quarter_count       <= '0;
        half_count          <= '0;
        three_quarter_count <= '0;
      end else if (taken) begin
        reading_count <= sat_inc(reading_count);
        // saturate once the sum reaches the all-ones value
        if (sum_wide[SW] || (&sum_wide[SW-1:0])) sum_of_percents <= '1;
        else sum_of_percents <= sum_wide[SW-1:0];
        if (pct > peak_percent) peak_percent <= pct;
        if (pct >= PCT_QUARTER) quarter_count <= sat_inc(quarter_count);
        if (pct >= PCT_HALF) half_count <= sat_inc(half_count);
        if (pct >= PCT_THREE_QUARTER) three_quarter_count <= sat_inc(three_quarter_count);
      end
    end
  end

endmodule

// ===== rtl/bfs_checker.sv =====
`include "assert_macros.svh"

module bfs_checker import bfs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                reading_taken,
  input logic [PCT_BITS-1:0] this_percent,
  input logic [PCT_BITS-1:0] peak_seen
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(this_percent) && $stable(peak_seen))
  `ASSERT_NOW(a_pct_range, out_valid, this_percent <= PCT_MAX)
  `ASSERT_NOW(a_peak_range, out_valid, peak_seen <= PCT_MAX)
  `ASSERT_NOW(a_no_reading_zero, out_valid && !reading_taken, this_percent == '0)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)

endmodule

bind buffer_fill_statistics bfs_checker u_bfs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .reading_taken (results.reading_taken),
  .this_percent  (results.this_percent),
  .peak_seen     (results.peak_seen)
);

// ===== sim/tb_buffer_fill_statistics.sv =====
module tb_buffer_fill_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  import bfs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [COUNT_OUT_W-1:0] COUNT_TOP = {COUNT_OUT_W{1'b1}};
  localparam logic [SUM_OUT_W-1:0] SUM_TOP = {SUM_OUT_W{1'b1}};
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 217;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic [LEVEL_W-1:0]         fill_level;
    logic signed [PCT_IN_W-1:0] direct_percent;
  } fill_item_t;

  typedef struct packed {
    logic                   reading_taken;
    logic [PCT_BITS-1:0]    this_percent;
    logic [COUNT_OUT_W-1:0] total_readings;
    logic [SUM_OUT_W-1:0]   percent_total;
    logic [PCT_BITS-1:0]    peak_seen;
    logic [COUNT_OUT_W-1:0] over_quarter;
    logic [COUNT_OUT_W-1:0] over_half;
    logic [COUNT_OUT_W-1:0] over_three_quarters;
  } fill_stats_t;

  logic clk;
  logic rst;

  bfs_cfg_if    cfg_ch ();
  bfs_item_if   item_ch ();
  bfs_result_if res_ch ();

  buffer_fill_statistics u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (res_ch)
  );

  fill_item_t  pending_fill_items[$];
  fill_stats_t expected_stats[$];
  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned failures;

  // Predicted block state
  logic [CFG_W-1:0]       pred_capacity;
  logic [COUNT_OUT_W-1:0] pred_readings;
  logic [SUM_OUT_W-1:0]   pred_sum;
  logic [PCT_BITS-1:0]    pred_peak;
  logic [COUNT_OUT_W-1:0] pred_quarter;
  logic [COUNT_OUT_W-1:0] pred_half;
  logic [COUNT_OUT_W-1:0] pred_three_q;

  // Idling control
  int unsigned idle_one_in;
  logic        steady;
  int unsigned send_gap;
  int unsigned stall_gap;
  fill_item_t  drive_item;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [COUNT_OUT_W-1:0] sat_inc(logic [COUNT_OUT_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic fill_stats_t predict_stats(fill_item_t it);
    fill_stats_t        r;
    longint unsigned    lvl;
    longint unsigned    cap;
    longint unsigned    scaled;
    logic [PCT_BITS-1:0] pct;
    logic               taken;
    pct = '0;
    taken = 1'b0;
    case (it.cmd)
      CMD_LEVEL: begin
        if (pred_capacity != 0) begin
          lvl = 64'(it.fill_level);
          cap = 64'(pred_capacity);
          scaled = (lvl * 200 + cap) / (cap * 2);
          pct = (scaled > PCT_MAX) ? PCT_MAX : scaled[PCT_BITS-1:0];
          taken = 1'b1;
        end
      end
      CMD_PERCENT: begin
        if (it.direct_percent[PCT_IN_W-1])
          pct = '0;
        else if (it.direct_percent[PCT_IN_W-2:0] > PCT_MAX)
          pct = PCT_MAX;
        else
          pct = it.direct_percent[PCT_BITS-1:0];
        taken = 1'b1;
      end
      CMD_CLEAR: begin
        pred_readings = '0;
        pred_sum = '0;
        pred_peak = '0;
        pred_quarter = '0;
        pred_half = '0;
        pred_three_q = '0;
      end
      default: ;
    endcase
    if (taken) begin
      pred_readings = sat_inc(pred_readings);
      // The sum saturates on its own, apart from the reading count
      if (pred_sum >= SUM_TOP - pct)
        pred_sum = SUM_TOP;
      else
        pred_sum = pred_sum + pct;
      if (pct > pred_peak)
        pred_peak = pct;
      if (pct >= PCT_QUARTER)
        pred_quarter = sat_inc(pred_quarter);
      if (pct >= PCT_HALF)
        pred_half = sat_inc(pred_half);
      if (pct >= PCT_THREE_QUARTER)
        pred_three_q = sat_inc(pred_three_q);
    end
    r.reading_taken       = taken;
    r.this_percent        = pct;
    r.total_readings      = pred_readings;
    r.percent_total       = pred_sum;
    r.peak_seen           = pred_peak;
    r.over_quarter        = pred_quarter;
    r.over_half           = pred_half;
    r.over_three_quarters = pred_three_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic queue_item(logic [CMD_W-1:0] c, logic [LEVEL_W-1:0] lvl,
                            logic [PCT_IN_W-1:0] pct);
    fill_item_t it;
    it.cmd = c;
    it.fill_level = lvl;
    it.direct_percent = pct;
    pending_fill_items.push_back(it);
    queued_total++;
  endtask

  // Hold until every queued item is accepted and answered, then let the block settle
  task automatic drain();
    while (accepted_total != queued_total || expected_stats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pred_capacity = value;
  endtask

  // Item driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        item_ch.valid <= 1'b0;
      end else if (pending_fill_items.size() != 0 && !steady &&
                   $urandom_range(1, idle_one_in) == 1) begin
        send_gap = $urandom_range(0, 7);
        item_ch.valid <= 1'b0;
      end else if (pending_fill_items.size() != 0) begin
        drive_item = pending_fill_items.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.cmd <= drive_item.cmd;
        item_ch.fill_level <= drive_item.fill_level;
        item_ch.direct_percent <= drive_item.direct_percent;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_gap = 0;
    end else if (stall_gap > 0) begin
      stall_gap--;
      res_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(1, idle_one_in) == 1) begin
      stall_gap = $urandom_range(0, 7);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Predict on every accepted item
  always @(posedge clk) begin
    fill_item_t seen;
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen.cmd = item_ch.cmd;
      seen.fill_level = item_ch.fill_level;
      seen.direct_percent = item_ch.direct_percent;
      expected_stats.push_back(predict_stats(seen));
      accepted_total++;
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    fill_stats_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result item arrived with none expected");
        failures++;
      end else begin
        want = expected_stats.pop_front();
        check_field("reading_taken", 64'(want.reading_taken), 64'(res_ch.reading_taken));
        check_field("this_percent", 64'(want.this_percent), 64'(res_ch.this_percent));
        check_field("total_readings", 64'(want.total_readings),
                    64'(res_ch.total_readings));
        check_field("percent_total", 64'(want.percent_total), 64'(res_ch.percent_total));
        check_field("peak_seen", 64'(want.peak_seen), 64'(res_ch.peak_seen));
        check_field("over_quarter", 64'(want.over_quarter), 64'(res_ch.over_quarter));
        check_field("over_half", 64'(want.over_half), 64'(res_ch.over_half));
        check_field("over_three_quarters", 64'(want.over_three_quarters),
                    64'(res_ch.over_three_quarters));
      end
    end
  end

  initial begin
    int unsigned cap;
    int unsigned k;
    int unsigned r;
    logic [CMD_W-1:0]    c;
    logic [LEVEL_W-1:0]  lvl;
    logic [PCT_IN_W-1:0] pct;

    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = CMD_LEVEL;
    item_ch.fill_level = '0;
    item_ch.direct_percent = '0;
    res_ch.ready = 1'b0;
    queued_total = 0;
    accepted_total = 0;
    failures = 0;
    steady = 1'b0;
    idle_one_in = 4;
    send_gap = 0;
    stall_gap = 0;
    pred_capacity = '0;
    pred_readings = '0;
    pred_sum = '0;
    pred_peak = '0;
    pred_quarter = '0;
    pred_half = '0;
    pred_three_q = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capacity zero after reset: level readings ignored; then percent clamping, an unused command and a clear
    queue_item(CMD_LEVEL, 16'd500, 16'd0);
    queue_item(CMD_PERCENT, 16'd0, 16'd0);
    queue_item(CMD_PERCENT, 16'd0, 16'd100);
    queue_item(CMD_PERCENT, 16'd0, 16'd101);
    queue_item(CMD_PERCENT, 16'd0, 16'hFFFF);
    queue_item(CMD_PERCENT, 16'd0, 16'h8000);
    queue_item(CMD_PERCENT, 16'd0, 16'h7FFF);
    queue_item(CMD_PERCENT, 16'd0, 16'd24);
    queue_item(CMD_PERCENT, 16'd0, 16'd25);
    queue_item(CMD_PERCENT, 16'd0, 16'd49);
    queue_item(CMD_PERCENT, 16'd0, 16'd50);
    queue_item(CMD_PERCENT, 16'd0, 16'd74);
    queue_item(CMD_PERCENT, 16'd0, 16'd75);
    queue_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    drain();

    write_capacity(16'hFFFF);
    queue_item(CMD_LEVEL, 16'd0, 16'd0);
    queue_item(CMD_LEVEL, 16'hFFFF, 16'd0);
    queue_item(CMD_LEVEL, 16'd32767, 16'd0);
    queue_item(CMD_LEVEL, 16'd1, 16'd0);
    drain();

    // Fill above capacity caps at full
    write_capacity(16'd1);
    queue_item(CMD_LEVEL, 16'd0, 16'd0);
    queue_item(CMD_LEVEL, 16'd2, 16'd0);
    queue_item(CMD_LEVEL, 16'hFFFF, 16'd0);
    drain();

    // Exact halves round up
    write_capacity(16'd200);
    queue_item(CMD_LEVEL, 16'd1, 16'd0);
    queue_item(CMD_LEVEL, 16'd99, 16'd0);
    queue_item(CMD_LEVEL, 16'd149, 16'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cap = 32'hFFFF;
        1: cap = 1;
        2: cap = 0;
        3: cap = 2;
        4: cap = 100;
        5: cap = 3;
        6: cap = $urandom_range(0, 32'hFFFF);
        7: cap = $urandom_range(1, 1000);
        default: cap = $urandom_range(1, 32'hFFFF);
      endcase
      write_capacity(cap[CFG_W-1:0]);
      idle_one_in = (ph % 3 == 0) ? 3 : ((ph % 3 == 1) ? 10 : 40);
      steady = (ph == PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          c = CMD_CLEAR;
        else if (r < 5)
          c = CMD_UNUSED;
        else if (r < 55)
          c = CMD_LEVEL;
        else
          c = CMD_PERCENT;
        k = $urandom_range(0, 9);
        if (k < 7)
          lvl = (cap == 0) ? LEVEL_W'($urandom_range(0, 32'hFFFF))
                           : LEVEL_W'($urandom_range(0, cap));
        else if (k < 9)
          lvl = LEVEL_W'($urandom_range(0, 32'hFFFF));
        else
          lvl = LEVEL_W'(cap + $urandom_range(0, 3));
        k = $urandom_range(0, 9);
        if (k < 7)
          pct = PCT_IN_W'($urandom_range(0, 100));
        else if (k < 8)
          pct = PCT_IN_W'($urandom_range(101, 32'h7FFF));
        else
          pct = PCT_IN_W'($urandom_range(0, 32'hFFFF));
        queue_item(c, lvl, pct);
      end
      drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== buffer_fill_statistics.f =====
+incdir+rtl
rtl/bfs_pkg.sv
rtl/bfs_if.sv
rtl/bfs_ctrl.sv
rtl/bfs_dp.sv
rtl/buffer_fill_statistics.sv
rtl/bfs_checker.sv
sim/tb_buffer_fill_statistics.sv
